### design/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int MAG_W         = 65;
    // quotient bits kept by the divider: 32 integer-range bits plus one guard bit
    localparam int QUOT_W        = 33;
    // partial remainder: numerator magnitude shifted by up to 34 fraction bits,
    // and divisor shifted by QUOT_W
    localparam int REM_W         = 98;
    localparam int TOL_W         = 16;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } cau_op_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic                     is_equal;
        logic [STATUS_W-1:0]      status;
    } cau_out_t;

    typedef logic [TOL_W-1:0] cau_cfg_t;

    // token that travels through the divider stages
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic                     dz;
        logic                     neg_re;
        logic                     neg_im;
        logic                     ovf_re;
        logic                     ovf_im;
        logic [PROD_W-1:0]        den;
        logic [REM_W-1:0]         rem_re;
        logic [REM_W-1:0]         rem_im;
        logic [QUOT_W-1:0]        q_re;
        logic [QUOT_W-1:0]        q_im;
        logic [DATA_W-1:0]        res_re;
        logic [DATA_W-1:0]        res_im;
        logic                     eq;
        logic [STATUS_W-1:0]      status;
    } cau_tok_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } cau_clamp_t;

    // clamp a sign/magnitude value into signed 32 bits
    function automatic cau_clamp_t clamp32(input logic neg, input logic [MAG_W-1:0] mag);
        cau_clamp_t c;
        c.sat = 1'b0;
        if (!neg) begin
            if (mag > MAG_W'(32'h7FFF_FFFF)) begin
                c.sat = 1'b1;
                c.val = 32'h7FFF_FFFF;
            end
            else begin
                c.val = mag[DATA_W-1:0];
            end
        end
        else begin
            if (mag > MAG_W'(32'h8000_0000)) begin
                c.sat = 1'b1;
                c.val = 32'h8000_0000;
            end
            else begin
                c.val = DATA_W'(0) - mag[DATA_W-1:0];
            end
        end
        return c;
    endfunction

endpackage

### design/cau_stream_if.sv
interface cau_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/cau_front.sv
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  cau_pkg::cau_in_t         in_data,
    input  logic [cau_pkg::TOL_W-1:0] tol,
    output logic                     tok_valid,
    output cau_pkg::cau_tok_t        tok
);

    localparam int DW = cau_pkg::DATA_W;
    localparam int PW = cau_pkg::PROD_W;
    localparam int MW = cau_pkg::MAG_W;
    localparam int RW = cau_pkg::REM_W;
    localparam int QW = cau_pkg::QUOT_W;
    localparam int OW = cau_pkg::OP_W;
    localparam int SW = cau_pkg::STATUS_W;

    // stage 1: operand registers
    logic                 v1_reg;
    logic [OW-1:0]        op1_reg;
    logic signed [DW-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // stage 2: products, add/sub/compare results
    logic                 v2_reg;
    logic [OW-1:0]        op2_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, srr_reg, sii_reg;
    logic [DW-1:0]        sre2_reg, sim2_reg;
    logic                 seq2_reg;
    logic [SW-1:0]        sst2_reg;
    logic                 dz2_reg;

    // stage 3: product sums
    logic                 v3_reg;
    logic [OW-1:0]        op3_reg;
    logic [PW-1:0]        ure_reg, uim_reg, den_reg;
    logic [DW-1:0]        sre3_reg, sim3_reg;
    logic                 seq3_reg;
    logic [SW-1:0]        sst3_reg;
    logic                 dz3_reg;

    // stage 4: token into the divider
    logic                 tok_valid_reg;
    cau_pkg::cau_tok_t    tok_reg, tok_next;

    // ---- stage 1 -> 2 combinational
    logic signed [DW:0]   ar33, ai33, br33, bi33;
    logic signed [DW:0]   s_re, s_im, d_re, d_im;
    logic signed [MW-1:0] se_re, se_im;
    logic [MW-1:0]        m_re, m_im;
    logic [DW:0]          abs_re, abs_im;
    cau_pkg::cau_clamp_t  c_re, c_im;
    logic [DW-1:0]        sre_next, sim_next;
    logic                 seq_next;
    logic [SW-1:0]        sst_next;

    always_comb
    begin
        ar33 = (DW+1)'(ar1_reg);
        ai33 = (DW+1)'(ai1_reg);
        br33 = (DW+1)'(br1_reg);
        bi33 = (DW+1)'(bi1_reg);
        d_re = ar33 - br33;
        d_im = ai33 - bi33;
        if (op1_reg == cau_pkg::OP_SUB)
        begin
            s_re = d_re;
            s_im = d_im;
        end
        else
        begin
            s_re = ar33 + br33;
            s_im = ai33 + bi33;
        end
        se_re = MW'(s_re);
        se_im = MW'(s_im);
        m_re  = s_re[DW] ? MW'(-se_re) : MW'(se_re);
        m_im  = s_im[DW] ? MW'(-se_im) : MW'(se_im);
        c_re  = cau_pkg::clamp32(s_re[DW], m_re);
        c_im  = cau_pkg::clamp32(s_im[DW], m_im);
        abs_re = d_re[DW] ? (DW+1)'(-d_re) : (DW+1)'(d_re);
        abs_im = d_im[DW] ? (DW+1)'(-d_im) : (DW+1)'(d_im);

        sre_next = '0;
        sim_next = '0;
        seq_next = 1'b0;
        sst_next = cau_pkg::ST_OK;
        if (op1_reg == cau_pkg::OP_ADD || op1_reg == cau_pkg::OP_SUB)
        begin
            sre_next = c_re.val;
            sim_next = c_im.val;
            if (c_re.sat || c_im.sat)
                sst_next = cau_pkg::ST_SAT;
        end
        else if (op1_reg == cau_pkg::OP_CMP)
        begin
            seq_next = (abs_re <= (DW+1)'(tol)) && (abs_im <= (DW+1)'(tol));
        end
    end

    // ---- stage 3 -> 4 combinational
    logic                neg_re, neg_im;
    logic [PW-1:0]       mag_re, mag_im;
    logic [MW-1:0]       rnd_re, rnd_im;
    logic [RW-1:0]       dlim;
    cau_pkg::cau_clamp_t pc_re, pc_im;

    always_comb
    begin
        neg_re = ure_reg[PW-1] && (ure_reg != {1'b1, {(PW-1){1'b0}}});
        neg_im = uim_reg[PW-1] && (uim_reg != {1'b1, {(PW-1){1'b0}}});
        mag_re = neg_re ? PW'(0) - ure_reg : ure_reg;
        mag_im = neg_im ? PW'(0) - uim_reg : uim_reg;
        rnd_re = (MW'(mag_re) + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        rnd_im = (MW'(mag_im) + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        pc_re  = cau_pkg::clamp32(neg_re, rnd_re);
        pc_im  = cau_pkg::clamp32(neg_im, rnd_im);
        dlim   = RW'(den_reg) << QW;

        tok_next.op     = op3_reg;
        tok_next.dz     = dz3_reg;
        tok_next.neg_re = neg_re;
        tok_next.neg_im = neg_im;
        tok_next.den    = den_reg;
        tok_next.rem_re = RW'(mag_re) << FRAC_BITS;
        tok_next.rem_im = RW'(mag_im) << FRAC_BITS;
        tok_next.ovf_re = tok_next.rem_re >= dlim;
        tok_next.ovf_im = tok_next.rem_im >= dlim;
        tok_next.q_re   = '0;
        tok_next.q_im   = '0;
        tok_next.res_re = sre3_reg;
        tok_next.res_im = sim3_reg;
        tok_next.eq     = seq3_reg;
        tok_next.status = sst3_reg;
        if (op3_reg == cau_pkg::OP_MUL)
        begin
            tok_next.res_re = pc_re.val;
            tok_next.res_im = pc_im.val;
            tok_next.status = (pc_re.sat || pc_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            tok_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg  <= in_data.opcode;
            ar1_reg  <= in_data.a_re;
            ai1_reg  <= in_data.a_im;
            br1_reg  <= in_data.b_re;
            bi1_reg  <= in_data.b_im;

            op2_reg  <= op1_reg;
            prr_reg  <= PW'(ar1_reg) * PW'(br1_reg);
            pii_reg  <= PW'(ai1_reg) * PW'(bi1_reg);
            pri_reg  <= PW'(ar1_reg) * PW'(bi1_reg);
            pir_reg  <= PW'(ai1_reg) * PW'(br1_reg);
            srr_reg  <= PW'(br1_reg) * PW'(br1_reg);
            sii_reg  <= PW'(bi1_reg) * PW'(bi1_reg);
            sre2_reg <= sre_next;
            sim2_reg <= sim_next;
            seq2_reg <= seq_next;
            sst2_reg <= sst_next;
            dz2_reg  <= (br1_reg == '0) && (bi1_reg == '0);

            op3_reg  <= op2_reg;
            if (op2_reg == cau_pkg::OP_DIV)
            begin
                ure_reg <= PW'(prr_reg + pii_reg);
                uim_reg <= PW'(pir_reg - pri_reg);
            end
            else
            begin
                ure_reg <= PW'(prr_reg - pii_reg);
                uim_reg <= PW'(pri_reg + pir_reg);
            end
            den_reg  <= PW'(srr_reg + sii_reg);
            sre3_reg <= sre2_reg;
            sim3_reg <= sim2_reg;
            seq3_reg <= seq2_reg;
            sst3_reg <= sst2_reg;
            dz3_reg  <= dz2_reg;

            tok_reg  <= tok_next;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

### design/cau_div_stage.sv
module cau_div_stage #(
    parameter int SHIFT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::cau_tok_t in_tok,
    output logic              out_valid,
    output cau_pkg::cau_tok_t out_tok
);

    localparam int RW = cau_pkg::REM_W;

    logic              valid_reg;
    cau_pkg::cau_tok_t tok_reg, tok_next;
    logic [RW-1:0]     dsh;

    // one restoring step for quotient bit SHIFT, both parts in parallel
    always_comb
    begin
        tok_next = in_tok;
        dsh      = RW'(in_tok.den) << SHIFT;
        if (in_tok.rem_re >= dsh)
        begin
            tok_next.rem_re      = in_tok.rem_re - dsh;
            tok_next.q_re[SHIFT] = 1'b1;
        end
        if (in_tok.rem_im >= dsh)
        begin
            tok_next.rem_im      = in_tok.rem_im - dsh;
            tok_next.q_im[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

### design/cau_back.sv
module cau_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::cau_tok_t in_tok,
    output logic              out_valid,
    output cau_pkg::cau_out_t out_data
);

    localparam int PW = cau_pkg::PROD_W;
    localparam int MW = cau_pkg::MAG_W;

    logic                out_valid_reg;
    cau_pkg::cau_out_t   out_data_reg, out_data_next;
    logic [PW-1:0]       r_re, r_im;
    logic                rnd_re, rnd_im;
    logic [MW-1:0]       q_re, q_im;
    cau_pkg::cau_clamp_t c_re, c_im;

    always_comb
    begin
        // remainder is below the divisor here; round half away from zero
        r_re   = in_tok.rem_re[PW-1:0];
        r_im   = in_tok.rem_im[PW-1:0];
        rnd_re = r_re >= (in_tok.den - r_re);
        rnd_im = r_im >= (in_tok.den - r_im);
        q_re   = in_tok.ovf_re ? '1 : MW'(in_tok.q_re) + MW'(rnd_re);
        q_im   = in_tok.ovf_im ? '1 : MW'(in_tok.q_im) + MW'(rnd_im);
        c_re   = cau_pkg::clamp32(in_tok.neg_re, q_re);
        c_im   = cau_pkg::clamp32(in_tok.neg_im, q_im);

        out_data_next.res_re   = in_tok.res_re;
        out_data_next.res_im   = in_tok.res_im;
        out_data_next.is_equal = in_tok.eq;
        out_data_next.status   = in_tok.status;
        if (in_tok.op == cau_pkg::OP_DIV)
        begin
            if (in_tok.dz)
            begin
                out_data_next.res_re = '0;
                out_data_next.res_im = '0;
                out_data_next.status = cau_pkg::ST_DIV_ZERO;
            end
            else
            begin
                out_data_next.res_re = c_re.val;
                out_data_next.res_im = c_im.val;
                out_data_next.status = (c_re.sat || c_im.sat) ? cau_pkg::ST_SAT
                                                              : cau_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide and tolerance compare of
// signed fixed-point complex operands (FRAC_BITS fraction bits). Fully pipelined:
// one transaction is accepted every cycle while the result side does not stall, and
// its result passes through 4 operand/product/sum stages, a 33-stage
// one-bit-per-stage restoring divider that every opcode passes through, and the
// output register.
// A stall on the result side freezes the whole pipeline. The tolerance register
// may only be written while no transaction is in flight.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cau_stream_if.sink    operands,
    cau_stream_if.source  results,
    cau_stream_if.sink    cfg
);

    localparam int QW = cau_pkg::QUOT_W;

    logic                       en;
    logic [cau_pkg::TOL_W-1:0]  tol_reg;
    logic                       front_valid;
    cau_pkg::cau_tok_t          front_tok;
    logic [QW:0]                div_valid;
    cau_pkg::cau_tok_t          div_tok [QW+1];
    logic                       back_valid;
    cau_pkg::cau_out_t          back_data;

    assign en             = !back_valid || results.ready;
    assign operands.ready = en;
    assign cfg.ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg.valid)
            tol_reg <= cfg.data;
    end

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (operands.valid),
        .in_data   (operands.data),
        .tol       (tol_reg),
        .tok_valid (front_valid),
        .tok       (front_tok)
    );

    assign div_valid[0] = front_valid;
    assign div_tok[0]   = front_tok;

    // MSB of the quotient first
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        cau_div_stage #(
            .SHIFT (QW - 1 - i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[i]),
            .in_tok    (div_tok[i]),
            .out_valid (div_valid[i+1]),
            .out_tok   (div_tok[i+1])
        );
    end

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid[QW]),
        .in_tok    (div_tok[QW]),
        .out_valid (back_valid),
        .out_data  (back_data)
    );

    assign results.valid = back_valid;
    assign results.data  = back_data;

endmodule
